@@ hw/rtl/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
// No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int DISC_W     = 34;
    localparam int ROOT_W     = 41;
    localparam int FRAC_SHIFT = 15;

    localparam logic [1:0] ST_NOT_QUAD = 2'd0;
    localparam logic [1:0] ST_NO_REAL  = 2'd1;
    localparam logic [1:0] ST_ONE_ROOT = 2'd2;
    localparam logic [1:0] ST_TWO_ROOT = 2'd3;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DISC_W-1:0] disc;
    } t_side;

endpackage

@@ hw/rtl/quadratic_root_solver.sv @@
// Pipelined real-root solver for a*x^2 + b*x + c, Q8.8 in, Q25.16 out.
// Depends on qrs_pkg.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+----------------------------------------
//   in      | i_in_valid   | o_in_ready   | i_coef_a, i_coef_b, i_coef_c
//   out     | o_out_valid  | i_out_ready  | o_status, o_discriminant, o_root_plus/minus
//
// One transfer per cycle sustained while i_out_ready is high. Reset clears all stage
// valid bits. Stages are input capture, products, discriminant, the bit-per-stage
// square root (SW stages), numerators, the bit-per-stage dividers (QW stages), output.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps

module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_c,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [qrs_pkg::DISC_W-1:0]   o_discriminant,
    output logic signed [qrs_pkg::ROOT_W-1:0]   o_root_plus,
    output logic signed [qrs_pkg::ROOT_W-1:0]   o_root_minus
);

    localparam int CW  = COEF_WIDTH;
    localparam int DW  = (2 * CW + 3 > 64) ? 64 : 2 * CW + 3;
    localparam int SW  = DW / 2;
    localparam int RDW = 2 * SW;
    localparam int RW  = SW + 2;
    localparam int NW  = ((CW > SW + 1) ? CW : SW + 1) + 1;
    localparam int QW  = NW - 1 + qrs_pkg::FRAC_SHIFT;
    localparam int DXW = (DW > qrs_pkg::DISC_W) ? DW : qrs_pkg::DISC_W;
    localparam int XW  = (QW + 1 > qrs_pkg::ROOT_W) ? QW + 1 : qrs_pkg::ROOT_W;

    logic en;
    logic r_ov;

    assign en         = ~r_ov | i_out_ready;
    assign o_in_ready = en;

    // stage 0: input capture
    logic                 r_v0;
    logic signed [CW-1:0] r_a0, r_b0, r_c0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= i_coef_a;
            r_b0 <= i_coef_b;
            r_c0 <= i_coef_c;
        end
    end

    // stage 1: products
    logic                     r_v1;
    logic signed [CW-1:0]     r_a1, r_b1;
    logic signed [2*CW-1:0]   r_bb, r_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1 <= r_a0;
            r_b1 <= r_b0;
            r_bb <= r_b0 * r_b0;
            r_ac <= r_a0 * r_c0;
        end
    end

    // stage 2: discriminant and classification, feeds square root
    logic signed [DW-1:0]  n_d;
    logic signed [DXW-1:0] n_dx;
    logic [1:0]            n_status;

    always_comb begin
        n_d  = DW'(r_bb) - (DW'(r_ac) <<< 2);
        n_dx = DXW'(n_d);
        if (r_a1 == '0) begin
            n_status = qrs_pkg::ST_NOT_QUAD;
        end else if (n_d[DW-1]) begin
            n_status = qrs_pkg::ST_NO_REAL;
        end else if (n_d == '0) begin
            n_status = qrs_pkg::ST_ONE_ROOT;
        end else begin
            n_status = qrs_pkg::ST_TWO_ROOT;
        end
    end

    logic                 r_sq_v    [SW+1];
    logic signed [CW-1:0] r_sq_a    [SW+1];
    logic signed [CW-1:0] r_sq_b    [SW+1];
    qrs_pkg::t_side       r_sq_side [SW+1];
    logic [RW-1:0]        r_sq_rem  [SW+1];
    logic [SW-1:0]        r_sq_root [SW+1];
    logic [RDW-1:0]       r_sq_rad  [SW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_a[0]           <= r_a1;
            r_sq_b[0]           <= r_b1;
            r_sq_side[0].status <= n_status;
            r_sq_side[0].disc   <= (r_a1 == '0) ? '0 : n_dx[qrs_pkg::DISC_W-1:0];
            r_sq_rem[0]         <= '0;
            r_sq_root[0]        <= '0;
            r_sq_rad[0]         <= n_d[DW-1] ? '0 : RDW'(n_d[DW-2:0]);
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SW; k++) begin : g_sq
        logic [RW-1:0] rem_pre;
        logic [RW-1:0] trial;
        logic          take;

        always_comb begin
            rem_pre = {r_sq_rem[k][RW-3:0], r_sq_rad[k][RDW-1 -: 2]};
            trial   = {r_sq_root[k], 2'b01};
            take    = (rem_pre >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_a[k+1]    <= r_sq_a[k];
                r_sq_b[k+1]    <= r_sq_b[k];
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_rem[k+1]  <= take ? rem_pre - trial : rem_pre;
                r_sq_root[k+1] <= {r_sq_root[k][SW-2:0], take};
                r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
            end
        end
    end

    // numerators, magnitudes and result signs, feeds dividers
    logic signed [NW-1:0] n_nb, n_ns, n_np, n_nm;
    logic [NW-1:0]        n_mp, n_mm;
    logic [CW-1:0]        n_amag;
    logic                 n_aneg;

    always_comb begin
        n_aneg = r_sq_a[SW][CW-1];
        n_amag = n_aneg ? (~r_sq_a[SW] + 1'b1) : r_sq_a[SW];
        n_nb   = -NW'(r_sq_b[SW]);
        n_ns   = $signed(NW'(r_sq_root[SW]));
        n_np   = n_nb + n_ns;
        n_nm   = n_nb - n_ns;
        n_mp   = n_np[NW-1] ? -n_np : n_np;
        n_mm   = n_nm[NW-1] ? -n_nm : n_nm;
    end

    logic           r_dv_v    [QW+1];
    qrs_pkg::t_side r_dv_side [QW+1];
    logic [CW-1:0]  r_dv_amag [QW+1];
    logic           r_dv_negp [QW+1];
    logic           r_dv_negm [QW+1];
    logic [CW:0]    r_dv_remp [QW+1];
    logic [CW:0]    r_dv_remm [QW+1];
    logic [QW-1:0]  r_dv_dvdp [QW+1];
    logic [QW-1:0]  r_dv_dvdm [QW+1];
    logic [QW-1:0]  r_dv_qp   [QW+1];
    logic [QW-1:0]  r_dv_qm   [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_sq_side[SW];
            r_dv_amag[0] <= n_amag;
            r_dv_negp[0] <= n_np[NW-1] ^ n_aneg;
            r_dv_negm[0] <= n_nm[NW-1] ^ n_aneg;
            r_dv_remp[0] <= '0;
            r_dv_remm[0] <= '0;
            r_dv_dvdp[0] <= {n_mp[NW-2:0], {qrs_pkg::FRAC_SHIFT{1'b0}}};
            r_dv_dvdm[0] <= {n_mm[NW-2:0], {qrs_pkg::FRAC_SHIFT{1'b0}}};
            r_dv_qp[0]   <= '0;
            r_dv_qm[0]   <= '0;
        end
    end

    // restoring dividers, one quotient bit per stage for each root
    for (genvar j = 0; j < QW; j++) begin : g_dv
        logic [CW:0] pre_p, pre_m, dsr;
        logic        tp, tm;

        always_comb begin
            dsr   = {1'b0, r_dv_amag[j]};
            pre_p = {r_dv_remp[j][CW-1:0], r_dv_dvdp[j][QW-1]};
            pre_m = {r_dv_remm[j][CW-1:0], r_dv_dvdm[j][QW-1]};
            tp    = (pre_p >= dsr);
            tm    = (pre_m >= dsr);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_side[j+1] <= r_dv_side[j];
                r_dv_amag[j+1] <= r_dv_amag[j];
                r_dv_negp[j+1] <= r_dv_negp[j];
                r_dv_negm[j+1] <= r_dv_negm[j];
                r_dv_remp[j+1] <= tp ? pre_p - dsr : pre_p;
                r_dv_remm[j+1] <= tm ? pre_m - dsr : pre_m;
                r_dv_dvdp[j+1] <= r_dv_dvdp[j] << 1;
                r_dv_dvdm[j+1] <= r_dv_dvdm[j] << 1;
                r_dv_qp[j+1]   <= {r_dv_qp[j][QW-2:0], tp};
                r_dv_qm[j+1]   <= {r_dv_qm[j][QW-2:0], tm};
            end
        end
    end

    // output register: apply signs, blank roots where none are real or a is zero
    logic signed [XW-1:0] n_xp, n_xm;
    logic                 n_has_root;

    always_comb begin
        n_xp       = $signed(XW'(r_dv_qp[QW]));
        n_xm       = $signed(XW'(r_dv_qm[QW]));
        n_xp       = r_dv_negp[QW] ? -n_xp : n_xp;
        n_xm       = r_dv_negm[QW] ? -n_xm : n_xm;
        n_has_root = (r_dv_side[QW].status == qrs_pkg::ST_ONE_ROOT) ||
                     (r_dv_side[QW].status == qrs_pkg::ST_TWO_ROOT);
    end

    logic [1:0]                        r_status;
    logic signed [qrs_pkg::DISC_W-1:0] r_disc;
    logic signed [qrs_pkg::ROOT_W-1:0] r_rp, r_rm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= r_dv_side[QW].status;
            r_disc   <= r_dv_side[QW].disc;
            r_rp     <= n_has_root ? n_xp[qrs_pkg::ROOT_W-1:0] : '0;
            r_rm     <= n_has_root ? n_xm[qrs_pkg::ROOT_W-1:0] : '0;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_status;
    assign o_discriminant = r_disc;
    assign o_root_plus    = r_rp;
    assign o_root_minus   = r_rm;

endmodule
